// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the shortest-distance block RTL.
// Depends on the including module having ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define AST_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define AST_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== hdl/dgsd_pkg.sv =====
// Package for the dense-graph shortest-distance block: payload types, codes,
// sequencer states and sizing constants. No dependencies.
`default_nettype none

package dgsd_pkg;

   // Defaults for the top-level parameters
   localparam int DefMaxNodes   = 16;
   localparam int DefWeightWidth = 16;

   // Fixed field widths of the request and response
   localparam int NODE_W    = 4;
   localparam int IN_WGT_W  = 16;
   localparam int CFG_W     = 5;
   localparam int DIST_W    = 20;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [CFG_W-1:0]  NUM_NODES_RST = CFG_W'(16);

   // Request operation codes
   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic              op;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [IN_WGT_W-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              reachable;
   } rsp_type;

   // One entry of the per-vertex working store
   typedef struct packed {
      logic              settled;
      logic              known;
      logic [DIST_W-1:0] path_len;
   } dist_entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE,
      ST_INIT,
      ST_SCAN,
      ST_SETTLE,
      ST_RELAX,
      ST_FETCH,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/dense_graph_shortest_distance.sv =====
// Dense-graph shortest-distance block: adjacency matrix memory, per-vertex
// distance memory and the sequencer that runs the search. Uses dgsd_pkg and
// assert_macros.svh.
//
// Usage: after reset the block sweeps all MAX_NODES*MAX_NODES entries of the
// edge matrix to zero, one entry a cycle, with busy high. A request is taken
// when start is high and busy is low. An edge write goes through ST_IDLE and
// ST_EDGE (one matrix port, two mirrored entries) and gives no response. A
// query with n active vertices makes one pass over the distance memory to
// initialize, then per round a scan for the nearest unsettled vertex, a
// settle write and, if that vertex has a known distance, a relaxation pass
// over its matrix row, all through the single read port of each memory. A
// query whose source or destination is not below n answers in the cycle
// after it is taken. The response is on rsp_item for exactly one cycle with
// rsp_valid high; it cannot be held off, so the receiver must take it then.
// num_nodes is written through csr_we/csr_wdata and should only change while
// busy is low.
`default_nettype none
`include "assert_macros.svh"

module dense_graph_shortest_distance
   import dgsd_pkg::*;
#(
   parameter int MAX_NODES    = DefMaxNodes,
   parameter int WEIGHT_WIDTH = DefWeightWidth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_item,
   output logic                  rsp_valid,
   output rsp_type               rsp_item,
   input  wire logic             csr_we,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   localparam int IDX_W      = $clog2(MAX_NODES);
   localparam int CNT_W      = $clog2(MAX_NODES + 1);
   localparam int EDGE_DEPTH = MAX_NODES * MAX_NODES;
   localparam int EA_W       = $clog2(EDGE_DEPTH);
   localparam int SUM_W      = ((WEIGHT_WIDTH > DIST_W) ? WEIGHT_WIDTH : DIST_W) + 1;
   localparam logic [EA_W-1:0] EDGE_LAST = EA_W'(EDGE_DEPTH - 1);

   // Flat matrix address of (row, col)
   function automatic logic [EA_W-1:0] edge_addr(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
      return EA_W'(row) * EA_W'(MAX_NODES) + EA_W'(col);
   endfunction

   // Memories
   logic [WEIGHT_WIDTH-1:0] edge_mem [EDGE_DEPTH];
   dist_entry_type          dist_mem [MAX_NODES];

   // Sequencer and datapath registers
   state_type               state_ff, state_in;
   logic [EA_W-1:0]         clr_ff, clr_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        rounds_ff, rounds_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CFG_W-1:0]        num_nodes_ff, num_nodes_in;
   logic [IDX_W-1:0]        a_ff, a_in;
   logic [IDX_W-1:0]        b_ff, b_in;
   logic [WEIGHT_WIDTH-1:0] weight_ff, weight_in;
   logic                    edge_ok_ff, edge_ok_in;
   logic                    miss_ff, miss_in;
   logic                    have_ff, have_in;
   logic [IDX_W-1:0]        best_ff, best_in;
   logic                    best_known_ff, best_known_in;
   logic [DIST_W-1:0]       best_dist_ff, best_dist_in;
   logic                    proc_vld_ff, proc_vld_in;
   logic [IDX_W-1:0]        proc_idx_ff, proc_idx_in;
   logic [WEIGHT_WIDTH-1:0] edge_rd_ff;
   dist_entry_type          dist_rd_ff;

   // Memory port controls
   logic                    edge_we;
   logic [EA_W-1:0]         edge_waddr, edge_raddr;
   logic [WEIGHT_WIDTH-1:0] edge_wdata;
   logic                    dist_we;
   logic [IDX_W-1:0]        dist_waddr, dist_raddr;
   dist_entry_type          dist_wdata;

   // Misc combinational
   logic [CNT_W-1:0]        act_n;
   logic [IDX_W-1:0]        cnt_idx;
   logic [IDX_W-1:0]        req_a_idx, req_b_idx;
   logic                    req_edge_ok, req_miss;
   logic                    take;
   logic [SUM_W-1:0]        sum_raw;
   logic [DIST_W-1:0]       sum_sat;
   logic                    relax_wr;

   assign cnt_idx   = cnt_ff[IDX_W-1:0];
   assign req_a_idx = IDX_W'(req_item.node_a);
   assign req_b_idx = IDX_W'(req_item.node_b);

   // Active vertex count: 0 acts as 1, above MAX_NODES clamps
   always_comb begin
      if (num_nodes_ff == '0) begin
         act_n = CNT_W'(1);
      end else if (int'(num_nodes_ff) > MAX_NODES) begin
         act_n = CNT_W'(MAX_NODES);
      end else begin
         act_n = CNT_W'(num_nodes_ff);
      end
   end

   assign req_edge_ok = (int'(req_item.node_a) < MAX_NODES) &&
                        (int'(req_item.node_b) < MAX_NODES);
   assign req_miss    = (int'(req_item.node_a) >= int'(act_n)) ||
                        (int'(req_item.node_b) >= int'(act_n));

   // Minimum scan compare: unknown ranks above known, ties go to the later index
   always_comb begin
      if (dist_rd_ff.settled) begin
         take = 1'b0;
      end else if (!have_ff) begin
         take = 1'b1;
      end else if (!dist_rd_ff.known) begin
         take = !best_known_ff;
      end else begin
         take = !best_known_ff || (dist_rd_ff.path_len <= best_dist_ff);
      end
   end

   // Relaxation adder with saturation
   assign sum_raw  = SUM_W'(best_dist_ff) + SUM_W'(edge_rd_ff);
   assign sum_sat  = (sum_raw > SUM_W'(DIST_MAX)) ? DIST_MAX : sum_raw[DIST_W-1:0];
   assign relax_wr = !dist_rd_ff.settled && (edge_rd_ff != '0) &&
                     (!dist_rd_ff.known || (sum_sat < dist_rd_ff.path_len));

   // Next state and memory controls
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      rounds_in     = rounds_ff;
      n_in          = n_ff;
      num_nodes_in  = csr_we ? csr_wdata : num_nodes_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      weight_in     = weight_ff;
      edge_ok_in    = edge_ok_ff;
      miss_in       = miss_ff;
      have_in       = 1'b0;
      best_in       = best_ff;
      best_known_in = best_known_ff;
      best_dist_in  = best_dist_ff;
      proc_vld_in   = 1'b0;
      proc_idx_in   = cnt_idx;

      edge_we    = 1'b0;
      edge_waddr = edge_addr(b_ff, a_ff);
      edge_wdata = weight_ff;
      edge_raddr = edge_addr(best_ff, cnt_idx);
      dist_we    = 1'b0;
      dist_waddr = cnt_idx;
      dist_wdata = '0;
      dist_raddr = cnt_idx;

      case (state_ff)
         ST_CLEAR: begin
            edge_we    = 1'b1;
            edge_waddr = clr_ff;
            edge_wdata = '0;
            if (clr_ff == EDGE_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + EA_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               a_in      = req_a_idx;
               b_in      = req_b_idx;
               weight_in = WEIGHT_WIDTH'(req_item.weight);
               n_in      = act_n;
               if (req_item.op == OP_EDGE) begin
                  // first mirror entry now, second next cycle
                  edge_ok_in = req_edge_ok;
                  edge_we    = req_edge_ok;
                  edge_waddr = edge_addr(req_a_idx, req_b_idx);
                  edge_wdata = WEIGHT_WIDTH'(req_item.weight);
                  state_in   = ST_EDGE;
               end else if (req_miss) begin
                  miss_in  = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  miss_in   = 1'b0;
                  cnt_in    = '0;
                  rounds_in = act_n - CNT_W'(1);
                  state_in  = ST_INIT;
               end
            end
         end
         ST_EDGE: begin
            edge_we  = edge_ok_ff;
            state_in = ST_IDLE;
         end
         ST_INIT: begin
            // only the source starts with a known distance
            dist_we          = 1'b1;
            dist_wdata.known = (cnt_idx == a_ff);
            if (cnt_ff == n_ff - CNT_W'(1)) begin
               cnt_in   = '0;
               state_in = (rounds_ff == '0) ? ST_FETCH : ST_SCAN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SCAN: begin
            have_in = have_ff;
            if (proc_vld_ff && take) begin
               have_in       = 1'b1;
               best_in       = proc_idx_ff;
               best_known_in = dist_rd_ff.known;
               best_dist_in  = dist_rd_ff.path_len;
            end
            if (cnt_ff != n_ff) begin
               proc_vld_in = 1'b1;
               cnt_in      = cnt_ff + CNT_W'(1);
            end else begin
               cnt_in   = '0;
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            dist_we             = 1'b1;
            dist_waddr          = best_ff;
            dist_wdata.settled  = 1'b1;
            dist_wdata.known    = best_known_ff;
            dist_wdata.path_len = best_dist_ff;
            if (best_known_ff) begin
               cnt_in   = '0;
               state_in = ST_RELAX;
            end else begin
               rounds_in = rounds_ff - CNT_W'(1);
               state_in  = (rounds_ff == CNT_W'(1)) ? ST_FETCH : ST_SCAN;
            end
         end
         ST_RELAX: begin
            // write back the entry read last cycle, read the next one
            if (proc_vld_ff && relax_wr) begin
               dist_we             = 1'b1;
               dist_waddr          = proc_idx_ff;
               dist_wdata.settled  = 1'b0;
               dist_wdata.known    = 1'b1;
               dist_wdata.path_len = sum_sat;
            end
            if (cnt_ff != n_ff) begin
               proc_vld_in = 1'b1;
               cnt_in      = cnt_ff + CNT_W'(1);
            end else begin
               cnt_in    = '0;
               rounds_in = rounds_ff - CNT_W'(1);
               state_in  = (rounds_ff == CNT_W'(1)) ? ST_FETCH : ST_SCAN;
            end
         end
         ST_FETCH: begin
            dist_raddr = b_ff;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rounds_ff    <= '0;
         num_nodes_ff <= NUM_NODES_RST;
         have_ff      <= 1'b0;
         proc_vld_ff  <= 1'b0;
         miss_ff      <= 1'b0;
         edge_ok_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rounds_ff    <= rounds_in;
         num_nodes_ff <= num_nodes_in;
         have_ff      <= have_in;
         proc_vld_ff  <= proc_vld_in;
         miss_ff      <= miss_in;
         edge_ok_ff   <= edge_ok_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      weight_ff     <= weight_in;
      best_ff       <= best_in;
      best_known_ff <= best_known_in;
      best_dist_ff  <= best_dist_in;
      proc_idx_ff   <= proc_idx_in;
   end

   // Edge matrix: one write, one registered read
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      edge_rd_ff <= edge_mem[edge_raddr];
   end

   // Per-vertex working store: one write, one registered read
   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      dist_rd_ff <= dist_mem[dist_raddr];
   end

   // Outputs
   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = (state_ff == ST_RESP);
   assign rsp_item.reachable  = !miss_ff && dist_rd_ff.known;
   assign rsp_item.distance   = rsp_item.reachable ? dist_rd_ff.path_len : '0;

   // Checks
   `AST_NEXT(a_accept_busy, start && !busy, busy)
   `AST_IMPL(a_unreach_zero, rsp_valid && !rsp_item.reachable, rsp_item.distance == '0)
   `AST_NEXT(a_single_rsp, rsp_valid, !rsp_valid)
   `AST_IMPL(a_cnt_bound, state_ff == ST_SCAN || state_ff == ST_RELAX, cnt_ff <= n_ff)
   `AST_IMPL(a_rsp_origin, rsp_valid, $past(state_ff == ST_FETCH) || $past(state_ff == ST_IDLE && start))

endmodule

`default_nettype wire

// ===== bench/dense_graph_shortest_distance_tb.sv =====
// Testbench for dense_graph_shortest_distance: drives edge writes and distance
// queries, predicts each unpinned answer with its own Dijkstra search, checks responses.
// Depends on dgsd_pkg and the block's RTL.
`default_nettype none

module dense_graph_shortest_distance_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dgsd_pkg::*;

   localparam int GRAPH_NODES   = DefMaxNodes;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DIRECTED_ROWS = 25;
   localparam int PHASES        = 9;
   // 15 hops of full weight along the chain 0..15
   localparam logic [DIST_W-1:0] CHAIN_SPAN = 20'd983025;

   // One row of the directed table; answer is used only when pinned is set
   typedef struct packed {
      req_type item;
      logic    pinned;
      rsp_type answer;
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_item;
   logic             rsp_valid;
   rsp_type          rsp_item;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;

   // Predictor state: edge matrix, vertex count and answers still due
   logic [IN_WGT_W-1:0] adjacency [GRAPH_NODES][GRAPH_NODES];
   logic [CFG_W-1:0]    node_count_reg;
   rsp_type             answers_due [$];
   logic                pin_next;
   rsp_type             pinned_answer;
   int                  fault_count = 0;
   int                  cycle_count = 0;

   // Directed requests: empty graph, self query, a max-weight chain, removal
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      {OP_QUERY, 4'd0,  4'd15, 16'h0000, 1'b1, 20'd0,      1'b0},
      {OP_QUERY, 4'd5,  4'd5,  16'hFFFF, 1'b1, 20'd0,      1'b1},
      {OP_EDGE,  4'd0,  4'd1,  16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd1,  4'd2,  16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd2,  4'd3,  16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd3,  4'd4,  16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd4,  4'd5,  16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd5,  4'd6,  16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd6,  4'd7,  16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd7,  4'd8,  16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd8,  4'd9,  16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd9,  4'd10, 16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd10, 4'd11, 16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd11, 4'd12, 16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd12, 4'd13, 16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd13, 4'd14, 16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd14, 4'd15, 16'hFFFF, 1'b0, 20'd0,      1'b0},
      {OP_QUERY, 4'd0,  4'd15, 16'h0000, 1'b1, CHAIN_SPAN, 1'b1},
      {OP_QUERY, 4'd15, 4'd0,  16'hA5A5, 1'b1, CHAIN_SPAN, 1'b1},
      {OP_EDGE,  4'd15, 4'd15, 16'h0001, 1'b0, 20'd0,      1'b0},
      {OP_EDGE,  4'd8,  4'd7,  16'h0000, 1'b0, 20'd0,      1'b0},
      {OP_QUERY, 4'd0,  4'd15, 16'h0000, 1'b1, 20'd0,      1'b0},
      {OP_EDGE,  4'd3,  4'd9,  16'h0001, 1'b0, 20'd0,      1'b0},
      {OP_QUERY, 4'd2,  4'd12, 16'h0000, 1'b0, 20'd0,      1'b0},
      {OP_QUERY, 4'd14, 4'd0,  16'h5A5A, 1'b0, 20'd0,      1'b0}
   };

   // Random phases: vertex count written, request count, sender idle percent
   logic [CFG_W-1:0] phase_setting [PHASES] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2,
                                                5'd5, 5'd17, 5'd9, 5'd16};
   int phase_items [PHASES] = '{220, 60, 160, 50, 80, 120, 200, 120, 115};
   int phase_idle  [PHASES] = '{0, 86, 35, 86, 0, 35, 86, 0, 35};

   dense_graph_shortest_distance u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Count 0 acts as one vertex, counts above the matrix size as the full matrix
   function automatic int active_vertices(logic [CFG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > GRAPH_NODES) return GRAPH_NODES;
      return int'(raw);
   endfunction

   // Dijkstra over the active vertices; unknown distances rank last and
   // ties go to the highest index
   function automatic rsp_type shortest_distance(logic [NODE_W-1:0] src,
                                                 logic [NODE_W-1:0] dst);
      logic [DIST_W-1:0] path_len [GRAPH_NODES];
      logic              known [GRAPH_NODES];
      logic              settled [GRAPH_NODES];
      logic [DIST_W:0]   sum;
      logic [DIST_W-1:0] best_dist;
      logic              have;
      logic              best_known;
      logic              take;
      int                n;
      int                nearest;
      rsp_type           answer;
      n = active_vertices(node_count_reg);
      answer = '0;
      // source or destination outside the active vertices: unreachable
      if (src >= n || dst >= n) return answer;
      for (int v = 0; v < GRAPH_NODES; v++) begin
         path_len[v] = '0;
         known[v] = 1'b0;
         settled[v] = 1'b0;
      end
      known[src] = 1'b1;
      for (int round = 0; round < n - 1; round++) begin
         have = 1'b0;
         best_known = 1'b0;
         best_dist = '0;
         nearest = 0;
         for (int v = 0; v < n; v++) begin
            if (!settled[v]) begin
               if (!have) take = 1'b1;
               else if (!known[v]) take = !best_known;
               else take = !best_known || path_len[v] <= best_dist;
               if (take) begin
                  have = 1'b1;
                  nearest = v;
                  best_known = known[v];
                  best_dist = path_len[v];
               end
            end
         end
         settled[nearest] = 1'b1;
         // relax the edges of the newly settled vertex, saturating the sum
         if (known[nearest]) begin
            for (int v = 0; v < n; v++) begin
               if (!settled[v] && adjacency[nearest][v] != 0) begin
                  sum = {1'b0, path_len[nearest]} + adjacency[nearest][v];
                  if (sum > DIST_MAX) sum = DIST_MAX;
                  if (!known[v] || sum[DIST_W-1:0] < path_len[v]) begin
                     path_len[v] = sum[DIST_W-1:0];
                     known[v] = 1'b1;
                  end
               end
            end
         end
      end
      if (known[dst]) begin
         answer.distance = path_len[dst];
         answer.reachable = 1'b1;
      end
      return answer;
   endfunction

   // Track register writes and accepted requests, then check any response
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         node_count_reg = NUM_NODES_RST;
         for (int i = 0; i < GRAPH_NODES; i++)
            for (int j = 0; j < GRAPH_NODES; j++)
               adjacency[i][j] = '0;
         answers_due.delete();
      end else begin
         if (csr_we) node_count_reg = csr_wdata;
         if (start && busy === 1'b0) begin
            if (req_item.op == OP_EDGE) begin
               adjacency[req_item.node_a][req_item.node_b] = req_item.weight;
               adjacency[req_item.node_b][req_item.node_a] = req_item.weight;
            end else if (pin_next) begin
               answers_due.push_back(pinned_answer);
            end else begin
               answers_due.push_back(shortest_distance(req_item.node_a, req_item.node_b));
            end
         end
         if (rsp_valid !== 1'b0) begin
            if (answers_due.size() == 0) begin
               $display("%0t: response with none due: distance %0d reachable %b",
                        $time, rsp_item.distance, rsp_item.reachable);
               fault_count++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_item.distance !== due.distance) begin
                  $display("%0t: distance expected %0d, got %0d",
                           $time, due.distance, rsp_item.distance);
                  fault_count++;
               end
               if (rsp_item.reachable !== due.reachable) begin
                  $display("%0t: reachable expected %b, got %b",
                           $time, due.reachable, rsp_item.reachable);
                  fault_count++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d responses due", $time, answers_due.size());
         $display("dense_graph_shortest_distance_tb NOT OK");
         $finish;
      end
   end

   // Present a request at the falling edge and hold it until taken
   task automatic issue_request(input req_type item, input logic pinned,
                                input rsp_type answer);
      logic taken;
      req_item = item;
      pin_next = pinned;
      pinned_answer = answer;
      start = 1'b1;
      do begin
         @(posedge clock);
         taken = (busy === 1'b0);
         @(negedge clock);
      end while (!taken);
   endtask

   task automatic idle_gap(input int pct);
      while ($urandom_range(1, 100) <= pct) begin
         start = 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic wait_for_answers();
      start = 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
   endtask

   // Change the vertex count only once the block has gone quiet
   task automatic write_node_count(input logic [CFG_W-1:0] value);
      wait_for_answers();
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (busy !== 1'b0) @(negedge clock);
      csr_wdata = value;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Mostly endpoints inside the active vertices; weights lean small so
   // paths compete, with some removals and full-scale weights
   function automatic req_type random_request(int span);
      req_type item;
      item.op = ($urandom_range(0, 99) < 45) ? OP_QUERY : OP_EDGE;
      item.node_a = ($urandom_range(0, 3) != 0) ? NODE_W'($urandom_range(0, span - 1))
                                                : NODE_W'($urandom_range(0, GRAPH_NODES - 1));
      item.node_b = ($urandom_range(0, 3) != 0) ? NODE_W'($urandom_range(0, span - 1))
                                                : NODE_W'($urandom_range(0, GRAPH_NODES - 1));
      case ($urandom_range(0, 9))
         0: item.weight = '0;
         1: item.weight = '1;
         2, 3, 4, 5, 6: item.weight = IN_WGT_W'($urandom_range(1, 20));
         default: item.weight = IN_WGT_W'($urandom);
      endcase
      return item;
   endfunction

   initial begin
      int span;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      pin_next = 1'b0;
      pinned_answer = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, back to back at the reset vertex count
      for (int r = 0; r < DIRECTED_ROWS; r++)
         issue_request(directed_rows[r].item, directed_rows[r].pinned,
                       directed_rows[r].answer);
      pin_next = 1'b0;

      // random phases over several vertex counts
      for (int p = 0; p < PHASES; p++) begin
         write_node_count(phase_setting[p]);
         span = active_vertices(phase_setting[p]);
         for (int k = 0; k < phase_items[p]; k++) begin
            idle_gap(phase_idle[p]);
            if ($urandom_range(0, 59) == 0) wait_for_answers();
            issue_request(random_request(span), 1'b0, '0);
         end
      end

      wait_for_answers();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fault_count == 0)
         $display("dense_graph_shortest_distance_tb OK");
      else
         $display("dense_graph_shortest_distance_tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
